[hw/rtl/radar_track_persistence_gate_assert.svh]
// Assertion macros shared by the gate RTL.
// Depends on nothing; define ASSERT_OFF to compile the checks away.
`ifndef RADAR_TRACK_PERSISTENCE_GATE_ASSERT_SVH
`define RADAR_TRACK_PERSISTENCE_GATE_ASSERT_SVH

`ifndef ASSERT_OFF
`define RTPG_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("rtpg check failed");
`define RTPG_ASSERT_NR(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("rtpg check failed");
`else
`define RTPG_ASSERT(lbl, clk, rst_n, prop)
`define RTPG_ASSERT_NR(lbl, clk, prop)
`endif

`endif

[hw/rtl/rtpg_pkg.sv]
// Types, register codes and constants of the radar track persistence gate.
// Depends on nothing; used by every module of the block.
package rtpg_pkg;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    REG_PROB_THRESHOLD  = 3'd0,
    REG_MIN_SCANS_SEEN  = 3'd1,
    REG_RANGE_GATE_LOW  = 3'd2,
    REG_RANGE_GATE_HIGH = 3'd3,
    REG_FLIP_LATERAL    = 3'd4,
    REG_SHIFT_X         = 3'd5,
    REG_SHIFT_Y         = 3'd6,
    REG_BASE_OPACITY    = 3'd7
  } cfg_reg_e;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;

  // Input word function codes.
  localparam logic FUNC_OBJECT      = 1'b0;
  localparam logic FUNC_END_OF_SCAN = 1'b1;

  // Opacity uses max(prob, 20), then a divide by 100 done as a multiply by
  // 5243 / 2^19, which is exact for products below 43690.
  localparam logic [6:0]  ProbFloor  = 7'd20;
  localparam logic [12:0] RecipMul   = 13'd5243;
  localparam int unsigned RecipShift = 19;

  typedef struct packed {
    logic               func;
    logic [7:0]         track_id;
    logic [6:0]         existence_prob;
    logic signed [15:0] raw_x;
    logic signed [15:0] raw_y;
  } in_word_t;

  typedef struct packed {
    logic               shown;
    logic [7:0]         out_id;
    logic signed [15:0] out_x;
    logic signed [15:0] out_y;
    logic [7:0]         opacity;
    logic [7:0]         scans_seen;
  } out_word_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;    // capture the input word and read the counter table
    logic update;  // bump the counter, write it back, square the position
    logic sweep;   // end of scan: drop counters of unseen tracks
    logic finish;  // gate and load the output register
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic func;       // function code of the word on the input
    logic out_stall;  // output register holds a word not yet taken
  } status_t;

  // Saturates an exact 18-bit sum to 16 bits.
  function automatic logic signed [15:0] sat16(input logic signed [17:0] v);
    logic signed [15:0] r;
    if (v > 18'sd32767) begin
      r = 16'sh7FFF;
    end else if (v < -18'sd32768) begin
      r = 16'sh8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

endpackage

[hw/rtl/rtpg_ctrl.sv]
// Controller state machine of the radar track persistence gate.
// Depends on rtpg_pkg; drives the command word of rtpg_datapath.
module rtpg_ctrl
  import rtpg_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  input  status_t status_i,
  output cmd_t    cmd_o
);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_LOOKUP = 2'd1;
  localparam logic [1:0] S_SCAN   = 2'd2;
  localparam logic [1:0] S_EVAL   = 2'd3;

  logic [1:0] state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = (status_i.func == FUNC_END_OF_SCAN) ? S_SCAN : S_LOOKUP;
        end
      end
      S_LOOKUP: begin
        cmd_o.update = 1'b1;
        state_d      = S_EVAL;
      end
      S_SCAN: begin
        cmd_o.sweep = 1'b1;
        state_d     = S_EVAL;
      end
      S_EVAL: begin
        // Wait until the output register is free.
        if (!status_i.out_stall) begin
          cmd_o.finish = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o = (state_q == S_IDLE);

endmodule

[hw/rtl/rtpg_datapath.sv]
// Datapath of the radar track persistence gate: configuration registers,
// counter table, position arithmetic, gates and output register. Uses rtpg_pkg.
module rtpg_datapath
  import rtpg_pkg::*;
#(
  parameter int unsigned TRACK_IDS  = 256,
  parameter int unsigned COUNT_BITS = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  in_word_t            in_word_i,
  input  cmd_t                cmd_i,
  output status_t             status_o,
  input  logic                out_ready_i,
  output logic                out_valid_o,
  output out_word_t           out_word_o
);

  localparam int unsigned IdxW = (TRACK_IDS > 1) ? $clog2(TRACK_IDS) : 1;
  localparam int unsigned CmpW = (COUNT_BITS > 8) ? COUNT_BITS : 8;

  // Configuration registers.
  logic [6:0]         prob_thr_q;
  logic [7:0]         min_scans_q;
  logic [14:0]        gate_lo_q;
  logic [14:0]        gate_hi_q;
  logic               flip_q;
  logic signed [15:0] shift_x_q;
  logic signed [15:0] shift_y_q;
  logic [7:0]         base_opac_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prob_thr_q  <= 7'd50;
      min_scans_q <= 8'd3;
      gate_lo_q   <= 15'd64;
      gate_hi_q   <= 15'd12800;
      flip_q      <= 1'b0;
      shift_x_q   <= '0;
      shift_y_q   <= '0;
      base_opac_q <= 8'd204;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_PROB_THRESHOLD:  prob_thr_q  <= cfg_data_i[6:0];
        REG_MIN_SCANS_SEEN:  min_scans_q <= cfg_data_i[7:0];
        REG_RANGE_GATE_LOW:  gate_lo_q   <= cfg_data_i[14:0];
        REG_RANGE_GATE_HIGH: gate_hi_q   <= cfg_data_i[14:0];
        REG_FLIP_LATERAL:    flip_q      <= cfg_data_i[0];
        REG_SHIFT_X:         shift_x_q   <= cfg_data_i;
        REG_SHIFT_Y:         shift_y_q   <= cfg_data_i;
        REG_BASE_OPACITY:    base_opac_q <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  // Squared gates, refreshed every cycle from the registers.
  logic [29:0] gate_lo2_q, gate_hi2_q;
  always_ff @(posedge clk_i) begin
    gate_lo2_q <= gate_lo_q * gate_lo_q;
    gate_hi2_q <= gate_hi_q * gate_hi_q;
  end

  // Input stage: position adjustment and opacity product.
  logic signed [17:0] sum_x, sum_y, lat;
  logic [6:0]         prob_floor;
  logic [IdxW-1:0]    in_idx;

  assign in_idx     = in_word_i.track_id[IdxW-1:0];
  assign lat        = flip_q ? -18'(in_word_i.raw_y) : 18'(in_word_i.raw_y);
  assign sum_x      = 18'(in_word_i.raw_x) + 18'(shift_x_q);
  assign sum_y      = lat + 18'(shift_y_q);
  assign prob_floor = (in_word_i.existence_prob < ProbFloor) ? ProbFloor
                                                             : in_word_i.existence_prob;

  logic [COUNT_BITS-1:0] count_mem [TRACK_IDS];
  logic [COUNT_BITS-1:0] rd_q;
  logic                  scan_q, idok_q;
  logic [7:0]            id_q;
  logic [IdxW-1:0]       idx_q;
  logic [6:0]            prob_q;
  logic signed [15:0]    x_q, y_q;
  logic [14:0]           oprod_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      rd_q    <= count_mem[in_idx];
      scan_q  <= in_word_i.func;
      idok_q  <= ({1'b0, in_word_i.track_id} < 9'(TRACK_IDS));
      id_q    <= in_word_i.track_id;
      idx_q   <= in_idx;
      prob_q  <= in_word_i.existence_prob;
      x_q     <= sat16(sum_x);
      y_q     <= sat16(sum_y);
      oprod_q <= base_opac_q * prob_floor;
    end
  end

  // Update stage: counter bump, write-back, squares and reciprocal product.
  logic [TRACK_IDS-1:0]  valid_q, seen_q;
  logic [COUNT_BITS-1:0] cnt_old, cnt_new;
  logic signed [31:0]    xx, yy;

  assign cnt_old = valid_q[idx_q] ? rd_q : '0;
  assign cnt_new = (cnt_old == {COUNT_BITS{1'b1}}) ? cnt_old : cnt_old + 1'b1;
  assign xx      = x_q * x_q;
  assign yy      = y_q * y_q;

  logic [COUNT_BITS-1:0] cnt_q;
  logic [30:0]           x2_q, y2_q;
  logic [27:0]           opq_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.update) begin
      cnt_q <= idok_q ? cnt_new : '0;
      x2_q  <= xx[30:0];
      y2_q  <= yy[30:0];
      opq_q <= oprod_q * RecipMul;
      if (idok_q) begin
        count_mem[idx_q] <= cnt_new;
      end
    end
  end

  // Valid bits stand for the zero reset of the table; seen marks per scan.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      seen_q  <= '0;
    end else if (cmd_i.sweep) begin
      valid_q <= valid_q & seen_q;
      seen_q  <= '0;
    end else if (cmd_i.update && idok_q) begin
      valid_q[idx_q] <= 1'b1;
      seen_q[idx_q]  <= 1'b1;
    end
  end

  // Evaluation stage.
  logic [31:0]     r2;
  logic            in_gate, pass;
  logic [CmpW-1:0] cnt_ext;
  logic [8:0]      opac_raw;
  logic [7:0]      opac_sat, scans_sat;
  out_word_t       res;

  assign r2        = {1'b0, x2_q} + {1'b0, y2_q};
  assign in_gate   = (r2 >= {2'b0, gate_lo2_q}) && (r2 <= {2'b0, gate_hi2_q});
  assign cnt_ext   = CmpW'(cnt_q);
  assign pass      = idok_q && (prob_q >= prob_thr_q) &&
                     (cnt_ext >= CmpW'(min_scans_q)) && in_gate;
  assign opac_raw  = opq_q[RecipShift +: 9];
  assign opac_sat  = opac_raw[8] ? 8'hFF : opac_raw[7:0];
  assign scans_sat = (cnt_ext > CmpW'(8'hFF)) ? 8'hFF : cnt_ext[7:0];

  always_comb begin
    res = '0;
    if (!scan_q) begin
      res.shown      = pass;
      res.out_id     = id_q;
      res.out_x      = x_q;
      res.out_y      = y_q;
      res.opacity    = pass ? opac_sat : 8'd0;
      res.scans_seen = scans_sat;
    end
  end

  out_word_t out_word_q;
  logic      out_valid_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      out_word_q <= res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.finish) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign out_word_o         = out_word_q;
  assign status_o.func      = in_word_i.func;
  assign status_o.out_stall = out_valid_q && !out_ready_i;

endmodule

[hw/rtl/radar_track_persistence_gate.sv]
// Radar track persistence gate, top level.
// An accepted word is read from the table, has its counter written back and is
// then gated into the output register, which waits while that register is still
// occupied; the next word is accepted only once the current one is through.
// End of scan clears all counters of unseen tracks together (valid bits).
// Reset (rst_ni, async, active low) empties the table and loads register defaults.
`include "radar_track_persistence_gate_assert.svh"

module radar_track_persistence_gate
  import rtpg_pkg::*;
#(
  parameter int unsigned TRACK_IDS  = 256,
  parameter int unsigned COUNT_BITS = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // Configuration write port.
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  // Input words.
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  in_word_t            in_word_i,
  // Output words.
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output out_word_t           out_word_o
);

  // The controller sequences each word through the datapath: an object word
  // reads its counter, writes back the bumped count, then gets gated; an end
  // of scan word runs the sweep instead. The output register lets the next
  // word be accepted while the previous result still waits to be taken.
  cmd_t    cmd;
  status_t status;

  rtpg_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  rtpg_datapath #(
    .TRACK_IDS  (TRACK_IDS),
    .COUNT_BITS (COUNT_BITS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_word_i   (in_word_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .out_word_o  (out_word_o)
  );

  // The output register is only loaded when it is free.
  `RTPG_ASSERT(a_finish_free, clk_i, rst_ni, cmd.finish |-> !status.out_stall)
  // An accepted word always starts either a lookup or a sweep next cycle.
  `RTPG_ASSERT(a_load_next, clk_i, rst_ni, cmd.load |=> (cmd.update || cmd.sweep))
  // The counter write-back lasts exactly one cycle.
  `RTPG_ASSERT(a_update_once, clk_i, rst_ni, cmd.update |=> !cmd.update && !in_ready_o)

endmodule

[tb/rtpg_gate_checker.sv]
`timescale 1ns / 100ps
// Scoreboard for the radar track persistence gate: mirrors the gate registers
// and the per-track scan table, predicts every output word and compares it.
// Depends on rtpg_pkg for the word types, register codes and function codes.
module rtpg_gate_checker
  import rtpg_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                in_valid_i,
  input  logic                in_ready_i,
  input  in_word_t            in_word_i,
  input  logic                out_valid_i,
  input  logic                out_ready_i,
  input  out_word_t           out_word_i,
  output int unsigned         fail_count_o,
  output int unsigned         pending_o,
  output int unsigned         checked_o,
  output int unsigned         shown_o
);

  localparam int unsigned OpacityProbFloor = 20;

  logic [7:0] scan_count [256];
  bit         seen_in_scan [256];

  logic [6:0]  thr_prob;
  logic [7:0]  scans_min;
  logic [14:0] gate_lo;
  logic [14:0] gate_hi;
  bit          lateral_flip;
  int          x_shift;
  int          y_shift;
  logic [7:0]  opacity_scale;

  out_word_t   expected_words [$];
  out_word_t   oldest;
  int unsigned mismatches;
  int unsigned checked;
  int unsigned shown;

  function automatic logic signed [15:0] clip_q8_7(int v);
    if (v > 32767) return 16'sh7FFF;
    if (v < -32768) return 16'sh8000;
    return v[15:0];
  endfunction

  // Advances the track table by one word and returns the word the gate owes.
  function automatic out_word_t gate_track_word(in_word_t w);
    out_word_t   r;
    int          lateral;
    longint      radius_sq;
    longint      lo_sq;
    longint      hi_sq;
    int unsigned prob_used;
    int unsigned opac;
    r = '0;
    if (w.func == FUNC_END_OF_SCAN) begin
      for (int i = 0; i < 256; i++) begin
        if (!seen_in_scan[i]) scan_count[i] = '0;
        seen_in_scan[i] = 1'b0;
      end
      return r;
    end
    lateral = lateral_flip ? -int'($signed(w.raw_y)) : int'($signed(w.raw_y));
    r.out_id = w.track_id;
    r.out_x  = clip_q8_7(int'($signed(w.raw_x)) + x_shift);
    r.out_y  = clip_q8_7(lateral + y_shift);
    if (scan_count[w.track_id] != 8'hFF) scan_count[w.track_id]++;
    seen_in_scan[w.track_id] = 1'b1;
    r.scans_seen = scan_count[w.track_id];
    if (w.existence_prob >= thr_prob && r.scans_seen >= scans_min) begin
      radius_sq = longint'($signed(r.out_x)) * longint'($signed(r.out_x))
                + longint'($signed(r.out_y)) * longint'($signed(r.out_y));
      lo_sq = longint'(gate_lo) * longint'(gate_lo);
      hi_sq = longint'(gate_hi) * longint'(gate_hi);
      if (radius_sq >= lo_sq && radius_sq <= hi_sq) begin
        prob_used = (w.existence_prob < OpacityProbFloor) ? OpacityProbFloor
                                                          : w.existence_prob;
        opac = opacity_scale * prob_used / 100;
        r.shown   = 1'b1;
        r.opacity = (opac > 255) ? 8'hFF : opac[7:0];
      end
    end
    return r;
  endfunction

  task automatic flag_field(string field, longint want, longint got);
    mismatches++;
    $display("%0t ns: %s mismatch: expected %0d, got %0d", $time, field, want, got);
  endtask

  task automatic compare_word(out_word_t want, out_word_t got);
    if (got.shown !== want.shown) begin
      flag_field("shown", longint'(want.shown), longint'(got.shown));
    end
    if (got.out_id !== want.out_id) begin
      flag_field("out_id", longint'(want.out_id), longint'(got.out_id));
    end
    if (got.out_x !== want.out_x) begin
      flag_field("out_x", longint'(want.out_x), longint'(got.out_x));
    end
    if (got.out_y !== want.out_y) begin
      flag_field("out_y", longint'(want.out_y), longint'(got.out_y));
    end
    if (got.opacity !== want.opacity) begin
      flag_field("opacity", longint'(want.opacity), longint'(got.opacity));
    end
    if (got.scans_seen !== want.scans_seen) begin
      flag_field("scans_seen", longint'(want.scans_seen), longint'(got.scans_seen));
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 256; i++) begin
        scan_count[i]   = '0;
        seen_in_scan[i] = 1'b0;
      end
      thr_prob      = 7'd50;
      scans_min     = 8'd3;
      gate_lo       = 15'd64;
      gate_hi       = 15'd12800;
      lateral_flip  = 1'b0;
      x_shift       = 0;
      y_shift       = 0;
      opacity_scale = 8'd204;
      expected_words.delete();
      mismatches    = 0;
      checked       = 0;
      shown         = 0;
      fail_count_o <= 0;
      pending_o    <= 0;
      checked_o    <= 0;
      shown_o      <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_reg_e'(cfg_idx_i))
          REG_PROB_THRESHOLD:  thr_prob      = cfg_data_i[6:0];
          REG_MIN_SCANS_SEEN:  scans_min     = cfg_data_i[7:0];
          REG_RANGE_GATE_LOW:  gate_lo       = cfg_data_i[14:0];
          REG_RANGE_GATE_HIGH: gate_hi       = cfg_data_i[14:0];
          REG_FLIP_LATERAL:    lateral_flip  = cfg_data_i[0];
          REG_SHIFT_X:         x_shift       = int'($signed(cfg_data_i));
          REG_SHIFT_Y:         y_shift       = int'($signed(cfg_data_i));
          REG_BASE_OPACITY:    opacity_scale = cfg_data_i[7:0];
          default: ;
        endcase
      end
      // Outputs are matched before the new input is queued, so a word
      // leaving the block can never be paired with one entering it.
      if (out_valid_i && out_ready_i) begin
        if (expected_words.size() == 0) begin
          mismatches++;
          $display("%0t ns: output word %h arrived with nothing expected",
                   $time, out_word_i);
        end else begin
          oldest = expected_words.pop_front();
          compare_word(oldest, out_word_i);
          checked++;
          if (out_word_i.shown === 1'b1) shown++;
        end
      end
      if (in_valid_i && in_ready_i) begin
        expected_words = {expected_words, gate_track_word(in_word_i)};
      end
      fail_count_o <= mismatches;
      pending_o    <= expected_words.size();
      checked_o    <= checked;
      shown_o      <= shown;
    end
  end

endmodule

[tb/tb_top.sv]
`timescale 1ns / 100ps
// Regression top for radar_track_persistence_gate: clock, reset, register
// programming, input words and output back-pressure; verdict from the checker.
// Depends on rtpg_pkg, the gate RTL and rtpg_gate_checker.
module tb_top
  import rtpg_pkg::*;
();

  // Clock: 4 ns period. Reset is held low from the start until the stimulus releases it.
  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // All block inputs start at known values before the first edge.
  logic                cfg_we_i   = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i  = REG_PROB_THRESHOLD;
  logic [CfgDataW-1:0] cfg_data_i = '0;
  logic                in_valid_i = 1'b0;
  logic                in_ready_o;
  in_word_t            in_word_i  = '0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  out_word_t           out_word_o;

  int unsigned fail_count;
  int unsigned pending_words;
  int unsigned checked_words;
  int unsigned shown_words;

  // Stimulus bookkeeping. The receiver flags are written with nonblocking
  // assignments because the receiver process reads them on the same edge.
  bit          rx_steady = 1'b0;
  int unsigned hold_requests = 0;
  bit          tx_steady;
  int unsigned words_sent;
  int unsigned scan_ends_sent;
  int unsigned gate_settings;

  radar_track_persistence_gate uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_word_i   (in_word_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_word_o  (out_word_o)
  );

  // The checker sits beside the block and only watches its ports.
  rtpg_gate_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_ready_i   (in_ready_o),
    .in_word_i    (in_word_i),
    .out_valid_i  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_word_i   (out_word_o),
    .fail_count_o (fail_count),
    .pending_o    (pending_words),
    .checked_o    (checked_words),
    .shown_o      (shown_words)
  );

  // Hard stop. The slowest legal run (about 1700 words, each waiting out the
  // longest sender gap and receiver stall, plus the forced hold-offs) ends
  // well within 3 ms, so the stop leaves a wide margin.
  initial begin
    #3_000_000;
    $display("radar_track_persistence_gate regression: fail");
    $finish;
  end

  // Receiver. Ready is re-decided whenever the current stretch runs out: either a
  // random stretch of ready or stall, a steady ready while the test asks for one,
  // or a long forced hold-off that lets the block fill and stall its input.
  initial begin
    int unsigned hold_left;
    int unsigned holds_done;
    int unsigned r;
    hold_left  = 0;
    holds_done = 0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (hold_left > 0) begin
        hold_left--;
      end else if (holds_done < hold_requests) begin
        holds_done++;
        out_ready_i <= 1'b0;
        hold_left = 300;
      end else if (rx_steady) begin
        out_ready_i <= 1'b1;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 60) begin
          out_ready_i <= 1'b1;
          hold_left = $urandom_range(0, 4);
        end else begin
          out_ready_i <= 1'b0;
          hold_left = (r < 92) ? $urandom_range(0, 2) : $urandom_range(10, 40);
        end
      end
    end
  end

  // Idle cycles before the next word: mostly none or a few, now and then long.
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (tx_steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  // Positions cluster inside the default gates, with the 16-bit extremes and
  // fully random values mixed in so that the offsets saturate.
  function automatic logic signed [15:0] pick_position();
    int unsigned r;
    int          v;
    r = $urandom_range(0, 19);
    if (r == 0) return 16'sh7FFF;
    if (r == 1) return 16'sh8000;
    if (r < 4) return 16'($urandom());
    v = int'($urandom_range(0, 18000)) - 9000;
    return v[15:0];
  endfunction

  // Probabilities cover the floor of 20, the threshold range and the values
  // above 100 that the 7-bit field still allows.
  function automatic logic [6:0] pick_probability();
    int unsigned r;
    r = $urandom_range(0, 19);
    if (r < 2) return 7'($urandom_range(101, 127));
    if (r == 2) return 7'd0;
    if (r == 3) return 7'd100;
    if (r == 4) return 7'd19;
    if (r == 5) return 7'd20;
    return 7'($urandom_range(0, 100));
  endfunction

  function automatic in_word_t object_word(logic [7:0] id, logic [6:0] prob,
                                           logic signed [15:0] x,
                                           logic signed [15:0] y);
    in_word_t w;
    w.func           = FUNC_OBJECT;
    w.track_id       = id;
    w.existence_prob = prob;
    w.raw_x          = x;
    w.raw_y          = y;
    return w;
  endfunction

  // End-of-scan words carry random junk in the other fields, which the
  // block has to ignore.
  function automatic in_word_t scan_end_word();
    in_word_t w;
    w      = in_word_t'({$urandom(), 16'($urandom())});
    w.func = FUNC_END_OF_SCAN;
    return w;
  endfunction

  // Offers one word after a random gap. Valid stays high after the
  // acceptance; the next call either keeps it high or drops it for its gap,
  // so valid sees a single assignment per edge.
  task automatic offer_word(in_word_t w);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_word_i  <= w;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (in_ready_o !== 1'b1);
    words_sent++;
    if (w.func == FUNC_END_OF_SCAN) scan_ends_sent++;
  endtask

  // Drops valid and waits until every expected word has come back. Each
  // word yields exactly one result, so the block is idle at that point.
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending_words != 0);
  endtask

  task automatic write_reg(cfg_reg_e idx, logic [15:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
  endtask

  // Writes all eight gate registers back to back, only while idle.
  task automatic program_gate(logic [15:0] prob_thr, logic [15:0] min_scans,
                              logic [15:0] gate_lo, logic [15:0] gate_hi,
                              logic [15:0] flip, logic [15:0] sx,
                              logic [15:0] sy, logic [15:0] opacity_scale);
    write_reg(REG_PROB_THRESHOLD, prob_thr);
    write_reg(REG_MIN_SCANS_SEEN, min_scans);
    write_reg(REG_RANGE_GATE_LOW, gate_lo);
    write_reg(REG_RANGE_GATE_HIGH, gate_hi);
    write_reg(REG_FLIP_LATERAL, flip);
    write_reg(REG_SHIFT_X, sx);
    write_reg(REG_SHIFT_Y, sy);
    write_reg(REG_BASE_OPACITY, opacity_scale);
    cfg_we_i <= 1'b0;
    gate_settings++;
  endtask

  // Scan traffic. A scan walks a pool of consecutive track ids, reporting
  // most of them, so that persistent tracks build up their counters while
  // dropped ones get cleared at the end of the scan. A few reports use a
  // random id, and now and then a second end-of-scan breaks the sequence and
  // clears the whole table. Without scans the counters only climb, which is
  // how they reach saturation.
  task automatic run_traffic(int unsigned n_words, int unsigned pool_size, bit scans);
    int unsigned sent;
    logic [7:0]  pool_base;
    logic [7:0]  id;
    sent      = 0;
    pool_base = 8'($urandom());
    while (sent < n_words) begin
      for (int k = 0; k < pool_size && sent < n_words; k++) begin
        if ($urandom_range(0, 99) < 85) begin
          id = ($urandom_range(0, 19) == 0) ? 8'($urandom()) : 8'(pool_base + k);
          offer_word(object_word(id, pick_probability(), pick_position(),
                                 pick_position()));
          sent++;
        end
      end
      if (scans && sent < n_words) begin
        offer_word(scan_end_word());
        sent++;
        if ($urandom_range(0, 14) == 0 && sent < n_words) begin
          offer_word(scan_end_word());
          sent++;
        end
      end
    end
  endtask

  initial begin
    words_sent     = 0;
    scan_ends_sent = 0;
    gate_settings  = 0;
    tx_steady      = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed words under the reset register values: threshold 50, three
    // scans, gates 64 to 12800, no flip, no offsets, opacity scale 204.
    // Track 0 is reported repeatedly within one scan until it passes.
    offer_word(object_word(8'd0, 7'd100, 16'sd1000, 16'sd0));
    offer_word(object_word(8'd0, 7'd100, 16'sd1000, 16'sd0));
    offer_word(object_word(8'd0, 7'd100, 16'sd1000, 16'sd0));
    // Probability exactly at the threshold, radius exactly at the low gate.
    offer_word(object_word(8'd0, 7'd50, 16'sd0, 16'sd64));
    // Just below the threshold and just below the low gate.
    offer_word(object_word(8'd0, 7'd49, 16'sd0, 16'sd63));
    // Radius exactly at the high gate, then one step beyond it.
    offer_word(object_word(8'd0, 7'd100, 16'sd12800, 16'sd0));
    offer_word(object_word(8'd0, 7'd100, 16'sd12801, 16'sd0));
    // Probability above 100: the opacity product saturates at 255.
    offer_word(object_word(8'd0, 7'd127, -16'sd9000, -16'sd9000));
    offer_word(object_word(8'd0, 7'd0, 16'sd2000, 16'sd2000));
    // Position extremes on the highest track id.
    offer_word(object_word(8'd255, 7'd100, 16'sh7FFF, 16'sh8000));
    offer_word(object_word(8'd255, 7'd100, 16'sh8000, 16'sh7FFF));
    offer_word(object_word(8'd128, 7'd19, 16'sd5000, 16'sd5000));
    offer_word(scan_end_word());
    // Second scan: tracks 0 and 255 keep their counts, track 128 is dropped.
    offer_word(object_word(8'd0, 7'd80, 16'sd3000, -16'sd3000));
    offer_word(object_word(8'd255, 7'd20, -16'sd100, 16'sd100));
    offer_word(object_word(8'd255, 7'd100, 16'sd0, 16'sd0));
    offer_word(scan_end_word());
    // An empty scan clears every counter.
    offer_word(scan_end_word());
    offer_word(object_word(8'd128, 7'd100, 16'sd640, 16'sd0));
    offer_word(object_word(8'd0, 7'd100, 16'sd640, 16'sd0));
    wait_idle();

    // Everything open: any probability, any count, radii up to 32767, full opacity,
    // lateral flip on. Both sides run without idling for this stretch.
    program_gate(16'd0, 16'd0, 16'd0, 16'd32767, 16'd1, 16'd0, 16'd0, 16'd255);
    tx_steady = 1'b1;
    rx_steady <= 1'b1;
    run_traffic(250, 8, 1'b1);
    wait_idle();
    tx_steady = 1'b0;
    rx_steady <= 1'b0;

    // Strictest counts: only saturated counters pass. With no scan ends and
    // one id per pool the counters climb to 255 and stick there.
    // The receiver also holds off for a long stretch while words keep coming.
    program_gate(16'd100, 16'd255, 16'd0, 16'd32767, 16'd0, 16'd0, 16'd0, 16'd0);
    hold_requests <= hold_requests + 1;
    run_traffic(320, 1, 1'b0);
    wait_idle();

    // Crossed gates: low above high, so nothing can pass the range test.
    program_gate(16'd50, 16'd3, 16'd20000, 16'd100, 16'd0, 16'd0, 16'd0, 16'd128);
    run_traffic(150, 12, 1'b1);
    wait_idle();

    // Extreme offsets with the flip on drive many coordinates into saturation.
    program_gate(16'd30, 16'd2, 16'd0, 16'd32767, 16'd1, 16'h7FFF, 16'h8000, 16'd255);
    run_traffic(150, 10, 1'b1);
    wait_idle();

    // Random settings in the neighborhood of real use.
    for (int p = 0; p < 5; p++) begin
      program_gate(16'($urandom_range(0, 100)), 16'($urandom_range(0, 6)),
                   16'($urandom_range(0, 2000)), 16'($urandom_range(3000, 20000)),
                   16'($urandom_range(0, 1)), 16'(int'($urandom_range(0, 8000)) - 4000),
                   16'(int'($urandom_range(0, 8000)) - 4000),
                   16'($urandom_range(0, 255)));
      tx_steady = ($urandom_range(0, 3) == 0);
      rx_steady <= ($urandom_range(0, 3) == 0);
      if (p == 2) hold_requests <= hold_requests + 1;
      run_traffic(160, $urandom_range(4, 24), 1'b1);
      wait_idle();
    end

    // A few more edges so that a stray extra output word would be caught.
    repeat (20) @(posedge clk_i);

    $display("Run covered %0d input words (%0d end-of-scan) over %0d gate settings.",
             words_sent, scan_ends_sent, gate_settings);
    $display("%0d output words checked, %0d objects passed every gate.",
             checked_words, shown_words);
    if (fail_count == 0) begin
      $display("radar_track_persistence_gate regression: pass");
    end else begin
      $display("radar_track_persistence_gate regression: fail");
    end
    $finish;
  end

endmodule
